FILE: hdl/etpi_pkg.sv
// Shared types, constants and fixed-point helpers of the energy throttle PI controller.
package etpi_pkg;

    typedef logic signed [31:0] q16_t;

    localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q16_MIN = 32'sh8000_0000;
    localparam q16_t Q16_ONE = 32'sh0001_0000;

    // Unit conversion constants, unsigned Q2.30 rounded to nearest.
    localparam q16_t K_KNOT  = 32'sd552380039;
    localparam q16_t K_FPM   = 32'sd5454608;
    localparam q16_t K_FOOT  = 32'sd327276508;
    localparam q16_t K_INV_G = 32'sd109565492;

    // Configuration register indexes.
    localparam logic [2:0] REG_TGT_SPEED = 3'd0;
    localparam logic [2:0] REG_TGT_ALT   = 3'd1;
    localparam logic [2:0] REG_ACC_GAIN  = 3'd2;
    localparam logic [2:0] REG_CLB_GAIN  = 3'd3;
    localparam logic [2:0] REG_PROP_GAIN = 3'd4;
    localparam logic [2:0] REG_INTG_GAIN = 3'd5;

    // Micro-step codes, issued in ascending order by the sequencer.
    localparam logic [4:0] C_MUL_SPD  = 5'd0;
    localparam logic [4:0] C_WB_SPD   = 5'd1;
    localparam logic [4:0] C_MUL_CLB  = 5'd2;
    localparam logic [4:0] C_WB_CLB   = 5'd3;
    localparam logic [4:0] C_MUL_ALT  = 5'd4;
    localparam logic [4:0] C_WB_ALT   = 5'd5;
    localparam logic [4:0] C_ERR      = 5'd6;
    localparam logic [4:0] C_WB_SPDD  = 5'd7;
    localparam logic [4:0] C_MUL_ALTD = 5'd8;
    localparam logic [4:0] C_WB_ALTD  = 5'd9;
    localparam logic [4:0] C_MUL_ACC  = 5'd10;
    localparam logic [4:0] C_WB_ACC   = 5'd11;
    localparam logic [4:0] C_DIVA_WB  = 5'd12;
    localparam logic [4:0] C_PIN      = 5'd13;
    localparam logic [4:0] C_MUL_P    = 5'd14;
    localparam logic [4:0] C_WB_P     = 5'd15;
    localparam logic [4:0] C_DIVB_WB  = 5'd16;
    localparam logic [4:0] C_SUM      = 5'd17;
    localparam logic [4:0] C_MUL_INC  = 5'd18;
    localparam logic [4:0] C_WB_INC   = 5'd19;
    localparam logic [4:0] C_INTEG    = 5'd20;
    localparam logic [4:0] C_MUL_I    = 5'd21;
    localparam logic [4:0] C_WB_I     = 5'd22;
    localparam logic [4:0] C_CMD      = 5'd23;
    localparam logic [4:0] C_NEG      = 5'd24;

    typedef struct packed {
        logic       load;
        logic       en;
        logic [4:0] step;
    } etpi_cmd_t;

    typedef struct packed {
        logic div_busy;
    } etpi_stat_t;

    function automatic q16_t sat34(input logic signed [33:0] v);
        q16_t r;
        if (v > 34'sd2147483647)
            r = Q16_MAX;
        else if (v < -34'sd2147483648)
            r = Q16_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // Round to nearest (halves upward), shift by 30 or 16, then saturate.
    function automatic q16_t rnd_sat(input logic signed [63:0] p, input logic sh30);
        logic signed [63:0] biased;
        logic signed [63:0] shifted;
        q16_t               r;
        biased  = p + (sh30 ? 64'sd536870912 : 64'sd32768);
        shifted = sh30 ? (biased >>> 30) : (biased >>> 16);
        if (shifted > 64'sd2147483647)
            r = Q16_MAX;
        else if (shifted < -64'sd2147483648)
            r = Q16_MIN;
        else
            r = shifted[31:0];
        return r;
    endfunction

endpackage

FILE: hdl/energy_throttle_pi_control_core.sv
// Top level of the total-energy throttle PI controller.
// Each item runs through the micro-step sequence, which holds two divisions by speed on
// the shared divider plus the multiply steps. Only one item is in progress at a time; a
// new item is taken while the last result still waits in the output register, and the next
// item stalls at its final step until that result has gone. Reset clears the configuration
// registers, the energy integral and all handshake state; no clearing pass.
module energy_throttle_pi_control_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // airspeed_kn [31:0], climb_fpm [63:32], altitude_ft [95:64], time_step [126:96], zero pad
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // throttle_cmd [31:0]
    output logic [31:0]  m_axis_tdata
);

    // The controller and the datapath talk only through these two groups.
    // The controller issues one micro-step per cycle unless held by the divider or output;
    // a step loads the shared 32x32 multiplier, writes back its rounded product, does a
    // saturating add, subtract or negate, or starts or reads the divider, or two of these.
    etpi_pkg::etpi_cmd_t  cmd;
    etpi_pkg::etpi_stat_t stat;
    etpi_pkg::q16_t       throttle_cmd;

    etpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The item's fields are captured on acceptance, so the input bus is free
    // again as soon as the handshake completes.
    etpi_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .airspeed_kn  (s_axis_tdata[31:0]),
        .climb_fpm    (s_axis_tdata[63:32]),
        .altitude_ft  (s_axis_tdata[95:64]),
        .time_step    (s_axis_tdata[126:96]),
        .cmd          (cmd),
        .stat         (stat),
        .throttle_cmd (throttle_cmd)
    );

    // The result register is only rewritten once the previous item has been
    // taken, so the data is stable for as long as tvalid is held.
    assign m_axis_tdata = throttle_cmd;

endmodule

FILE: hdl/etpi_div.sv
// Radix-4 restoring divider for Q16.16 quotients with a divisor of at least 1.0.
module etpi_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  etpi_pkg::q16_t       num,
    input  etpi_pkg::q16_t       den,
    output logic                 busy,
    output etpi_pkg::q16_t       quot
);

    localparam logic [4:0] DIV_STEPS = 5'd16;

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [30:0] rem_reg;
    logic [31:0] low_reg;
    logic [31:0] q_reg;
    logic [30:0] den_reg;
    logic        neg_reg;

    logic [31:0] mag;
    logic [31:0] dvs;
    logic [31:0] s1;
    logic [31:0] r1;
    logic [31:0] s2;
    logic [31:0] r2;
    logic        ge1;
    logic        ge2;

    assign mag = num[31] ? (~num + 32'd1) : num;
    assign dvs = {1'b0, den_reg};

    always_comb
    begin
        s1  = {rem_reg, low_reg[31]};
        ge1 = (s1 >= dvs);
        r1  = ge1 ? (s1 - dvs) : s1;
        s2  = {r1[30:0], low_reg[30]};
        ge2 = (s2 >= dvs);
        r2  = ge2 ? (s2 - dvs) : s2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            // The high half of |num| << 16 is below the divisor, so 32 quotient bits suffice.
            rem_reg <= {15'd0, mag[31:16]};
            low_reg <= {mag[15:0], 16'd0};
            q_reg   <= 32'd0;
            den_reg <= den[30:0];
            neg_reg <= num[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= r2[30:0];
            low_reg <= {low_reg[29:0], 2'b00};
            q_reg   <= {q_reg[29:0], ge1, ge2};
        end
    end

    assign busy = busy_reg;
    assign quot = neg_reg ? (~q_reg + 32'd1) : (q_reg[31] ? etpi_pkg::Q16_MAX : q_reg);

endmodule

FILE: hdl/etpi_dpath.sv
// Datapath: configuration registers, shared multiplier, divider and working registers.
module etpi_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  etpi_pkg::q16_t       airspeed_kn,
    input  etpi_pkg::q16_t       climb_fpm,
    input  etpi_pkg::q16_t       altitude_ft,
    input  logic [30:0]          time_step,
    input  etpi_pkg::etpi_cmd_t  cmd,
    output etpi_pkg::etpi_stat_t stat,
    output etpi_pkg::q16_t       throttle_cmd
);

    etpi_pkg::q16_t tgt_speed_reg, tgt_alt_reg, acc_gain_reg, clb_gain_reg;
    etpi_pkg::q16_t prop_gain_reg, intg_gain_reg, integral_reg;

    etpi_pkg::q16_t kn_reg, fpm_reg, ft_reg;
    logic [30:0]    dt_reg;
    etpi_pkg::q16_t speed_reg, climb_reg, alt_reg, spd_err_reg, alt_err_reg;
    etpi_pkg::q16_t spd_d_reg, alt_d_reg, acc_reg, ratio_reg, fpa_reg, p_in_reg;
    etpi_pkg::q16_t p_term_reg, sum_reg, incr_reg, i_term_reg, cmd_val_reg, out_reg;

    logic signed [63:0] prod_reg;
    logic               sh30_reg;

    etpi_pkg::q16_t mul_a, mul_b, prod_r, div_q, div_num;
    logic           div_go, div_busy;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            etpi_pkg::C_MUL_SPD:  begin mul_a = kn_reg;        mul_b = etpi_pkg::K_KNOT;  end
            etpi_pkg::C_MUL_CLB:  begin mul_a = fpm_reg;       mul_b = etpi_pkg::K_FPM;   end
            etpi_pkg::C_MUL_ALT:  begin mul_a = ft_reg;        mul_b = etpi_pkg::K_FOOT;  end
            etpi_pkg::C_ERR:      begin mul_a = spd_err_reg;   mul_b = acc_gain_reg;      end
            etpi_pkg::C_MUL_ALTD: begin mul_a = alt_err_reg;   mul_b = clb_gain_reg;      end
            etpi_pkg::C_MUL_ACC:  begin mul_a = spd_d_reg;     mul_b = etpi_pkg::K_INV_G; end
            etpi_pkg::C_MUL_INC:  begin mul_a = sum_reg;       mul_b = {1'b0, dt_reg};    end
            etpi_pkg::C_MUL_P:    begin mul_a = prop_gain_reg; mul_b = p_in_reg;          end
            etpi_pkg::C_MUL_I:    begin mul_a = intg_gain_reg; mul_b = integral_reg;      end
            default:              begin mul_a = '0;            mul_b = '0;                end
        endcase
    end

    assign prod_r = etpi_pkg::rnd_sat(prod_reg, sh30_reg);

    // The ratio division starts once speed and climb rate are known; the
    // flight-path division follows it on the same unit.
    assign div_go  = cmd.en && ((cmd.step == etpi_pkg::C_MUL_ALT) ||
                                (cmd.step == etpi_pkg::C_DIVA_WB));
    assign div_num = (cmd.step == etpi_pkg::C_MUL_ALT) ? climb_reg : alt_d_reg;

    etpi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (div_num),
        .den   (speed_reg),
        .busy  (div_busy),
        .quot  (div_q)
    );

    assign stat.div_busy = div_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_speed_reg <= '0;
            tgt_alt_reg   <= '0;
            acc_gain_reg  <= '0;
            clb_gain_reg  <= '0;
            prop_gain_reg <= '0;
            intg_gain_reg <= '0;
            integral_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    etpi_pkg::REG_TGT_SPEED: tgt_speed_reg <= cfg_data;
                    etpi_pkg::REG_TGT_ALT:   tgt_alt_reg   <= cfg_data;
                    etpi_pkg::REG_ACC_GAIN:  acc_gain_reg  <= cfg_data;
                    etpi_pkg::REG_CLB_GAIN:  clb_gain_reg  <= cfg_data;
                    etpi_pkg::REG_PROP_GAIN: prop_gain_reg <= cfg_data;
                    etpi_pkg::REG_INTG_GAIN: intg_gain_reg <= cfg_data;
                    default:                 ;
                endcase
            end
            if (cmd.en && (cmd.step == etpi_pkg::C_INTEG))
                integral_reg <= etpi_pkg::sat34({{2{integral_reg[31]}}, integral_reg} +
                                                {{2{incr_reg[31]}}, incr_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kn_reg  <= airspeed_kn;
            fpm_reg <= climb_fpm;
            ft_reg  <= altitude_ft;
            dt_reg  <= time_step;
        end
        if (cmd.en)
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
            sh30_reg <= (cmd.step == etpi_pkg::C_MUL_SPD) || (cmd.step == etpi_pkg::C_MUL_CLB) ||
                        (cmd.step == etpi_pkg::C_MUL_ALT) || (cmd.step == etpi_pkg::C_MUL_ACC);
            case (cmd.step)
                etpi_pkg::C_WB_SPD:
                    speed_reg <= (prod_r < etpi_pkg::Q16_ONE) ? etpi_pkg::Q16_ONE : prod_r;
                etpi_pkg::C_WB_CLB:
                    climb_reg <= prod_r;
                etpi_pkg::C_WB_ALT:
                begin
                    alt_reg     <= prod_r;
                    spd_err_reg <= etpi_pkg::sat34({{2{tgt_speed_reg[31]}}, tgt_speed_reg} -
                                                   {{2{speed_reg[31]}}, speed_reg});
                end
                etpi_pkg::C_ERR:
                    alt_err_reg <= etpi_pkg::sat34({{2{tgt_alt_reg[31]}}, tgt_alt_reg} -
                                                   {{2{alt_reg[31]}}, alt_reg});
                etpi_pkg::C_WB_SPDD: spd_d_reg <= prod_r;
                etpi_pkg::C_WB_ALTD: alt_d_reg <= prod_r;
                etpi_pkg::C_WB_ACC:  acc_reg   <= prod_r;
                etpi_pkg::C_DIVA_WB: ratio_reg <= div_q;
                etpi_pkg::C_PIN:
                    p_in_reg <= etpi_pkg::sat34(34'sd0 - {{2{ratio_reg[31]}}, ratio_reg} -
                                                {{2{acc_reg[31]}}, acc_reg});
                etpi_pkg::C_WB_P:    p_term_reg <= prod_r;
                etpi_pkg::C_DIVB_WB: fpa_reg    <= div_q;
                etpi_pkg::C_SUM:
                    sum_reg <= etpi_pkg::sat34({{2{acc_reg[31]}}, acc_reg} +
                                               {{2{fpa_reg[31]}}, fpa_reg});
                etpi_pkg::C_WB_INC:  incr_reg   <= prod_r;
                etpi_pkg::C_WB_I:    i_term_reg <= prod_r;
                etpi_pkg::C_CMD:
                    cmd_val_reg <= etpi_pkg::sat34({{2{p_term_reg[31]}}, p_term_reg} +
                                                   {{2{i_term_reg[31]}}, i_term_reg});
                etpi_pkg::C_NEG:
                    out_reg <= (cmd_val_reg == etpi_pkg::Q16_MIN) ? etpi_pkg::Q16_MAX
                                                                  : (32'sd0 - cmd_val_reg);
                default: ;
            endcase
        end
    end

    assign throttle_cmd = out_reg;

endmodule

FILE: hdl/etpi_ctrl.sv
// Sequencer: steps the datapath through one item and runs the input and output handshakes.
module etpi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  etpi_pkg::etpi_stat_t stat,
    output etpi_pkg::etpi_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic       state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       ovalid_reg, ovalid_next;
    logic       hold;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        cmd.step    = step_reg;
        hold        = 1'b0;

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                    step_next  = etpi_pkg::C_MUL_SPD;
                end
            end
            ST_RUN:
            begin
                // Wait for the divider before taking its quotient, and for a
                // free output register before the final step.
                hold = ((step_reg inside {etpi_pkg::C_DIVA_WB, etpi_pkg::C_DIVB_WB}) &&
                        stat.div_busy) ||
                       ((step_reg == etpi_pkg::C_NEG) && ovalid_reg && !out_ready);
                if (!hold)
                begin
                    cmd.en = 1'b1;
                    if (step_reg == etpi_pkg::C_NEG)
                    begin
                        state_next  = ST_IDLE;
                        ovalid_next = 1'b1;
                    end
                    else
                        step_next = step_reg + 5'd1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= etpi_pkg::C_MUL_SPD;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;

endmodule

FILE: hdl/etpi_check.sv
// Port-level checker for the energy throttle PI controller, bound to the top level.
module etpi_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // One item at a time: after an acceptance the input side closes.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // A result appears only at the end of an item's processing.
    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result raised without an item in progress");

    // Input side open in the cycle a result is raised, as the sequencer is idle again.
    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("sequencer not idle after finishing an item");

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result withdrawn before it was taken");

    a_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind energy_throttle_pi_control_core etpi_check u_etpi_check (.*);
